>>> sv/b64e_pkg.sv
`default_nettype none

package b64e_pkg;

  localparam int unsigned CharW         = 7;
  localparam int unsigned MaxChars      = 4;
  localparam int unsigned QueueDepthDef = 2;
  localparam logic [CharW-1:0] PadChar  = 7'd61;  // '='

  // position inside a three-byte group
  typedef enum logic [1:0] {
    PhStart = 2'd0,
    PhOne   = 2'd1,
    PhTwo   = 2'd2
  } phase_e;

  // everything one input byte causes, handed from front to back
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [1:0]                     last_idx;  // index of the final char of the word
    logic                           eom;
  } job_t;

  // standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [CharW-1:0] b64_char(input logic [5:0] v);
    logic [CharW-1:0] v7;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      return v7 + 7'd65;
    end else if (v < 6'd52) begin
      return v7 + 7'd71;
    end else if (v < 6'd62) begin
      return v7 - 7'd4;
    end else if (v == 6'd62) begin
      return 7'd43;
    end else begin
      return 7'd47;
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/b64e_front.sv
`default_nettype none

module b64e_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          final_byte_i,
  output b64e_pkg::job_t     job_o
);
  import b64e_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic [5:0] sx0, sx1;

  // next group position and held bits
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    if (take_i) begin
      unique case (phase_q)
        PhOne: begin
          phase_d = PhTwo;
          left_d  = data_byte_i[3:0];
        end
        PhTwo: begin
          phase_d = PhStart;
          left_d  = 4'd0;
        end
        default: begin
          phase_d = PhOne;
          left_d  = {2'b00, data_byte_i[1:0]};
        end
      endcase
      if (final_byte_i) begin
        phase_d = PhStart;
        left_d  = 4'd0;
      end
    end
  end

  // characters this byte completes, plus flush and pad on the final byte
  always_comb begin
    sx0             = 6'd0;
    sx1             = 6'd0;
    job_o.chars     = '0;
    job_o.last_idx  = 2'd0;
    job_o.eom       = final_byte_i;
    unique case (phase_q)
      PhOne: begin
        sx0 = {left_q[1:0], data_byte_i[7:4]};
        sx1 = {data_byte_i[3:0], 2'b00};
        job_o.chars[0] = b64_char(sx0);
        if (final_byte_i) begin
          job_o.chars[1] = b64_char(sx1);
          job_o.chars[2] = PadChar;
          job_o.last_idx = 2'd2;
        end
      end
      PhTwo: begin
        sx0 = {left_q[3:0], data_byte_i[7:6]};
        sx1 = data_byte_i[5:0];
        job_o.chars[0] = b64_char(sx0);
        job_o.chars[1] = b64_char(sx1);
        job_o.last_idx = 2'd1;
      end
      default: begin
        sx0 = data_byte_i[7:2];
        sx1 = {data_byte_i[1:0], 4'b0000};
        job_o.chars[0] = b64_char(sx0);
        if (final_byte_i) begin
          job_o.chars[1] = b64_char(sx1);
          job_o.chars[2] = PadChar;
          job_o.chars[3] = PadChar;
          job_o.last_idx = 2'd3;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      left_q  <= 4'd0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

`ifndef NO_ASSERTIONS
  // at the start of a group nothing is held
  a_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhStart |-> left_q == 4'd0)
    else $error("held bits left over at group start");
  // a final byte always returns to the start of a group
  a_final_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && final_byte_i |=> phase_q == PhStart)
    else $error("group position not cleared after final byte");
`endif

endmodule

`default_nettype wire

>>> sv/b64e_fifo.sv
`default_nettype none

module b64e_fifo #(
  parameter int unsigned Depth = b64e_pkg::QueueDepthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire b64e_pkg::job_t  push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output b64e_pkg::job_t       pop_data_o
);
  import b64e_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  DepthCnt = CntW'(Depth);

  job_t             mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == DepthCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("queue count beyond depth");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("word pushed into full queue");
`endif

endmodule

`default_nettype wire

>>> sv/b64e_back.sv
`default_nettype none

module b64e_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  input  wire b64e_pkg::job_t  job_i,
  output logic                 job_pop_o,
  output logic                 m_tvalid_o,
  input  wire logic            m_tready_i,
  output logic [7:0]           m_tdata_o,
  output logic                 m_tlast_o,
  output logic                 m_tuser_o
);
  import b64e_pkg::*;

  job_t             job_q;
  logic             busy_q;
  logic [1:0]       idx_q;
  logic             out_valid_q;
  logic [CharW-1:0] out_char_q;
  logic             out_last_q, out_eom_q;
  logic             slot_free, adv, done;

  assign slot_free = !out_valid_q || m_tready_i;
  assign adv       = busy_q && slot_free;
  assign done      = adv && (idx_q == job_q.last_idx);
  assign job_pop_o = job_valid_i && (!busy_q || done);

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (adv) begin
      out_char_q <= job_q.chars[idx_q];
      out_last_q <= (idx_q == job_q.last_idx);
      out_eom_q  <= (idx_q == job_q.last_idx) && job_q.eom;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 2'd0;
      end else if (done) begin
        busy_q <= 1'b0;
        idx_q  <= 2'd0;
      end else if (adv) begin
        idx_q <= idx_q + 1'b1;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {1'b0, out_char_q};
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_eom_q;

`ifndef NO_ASSERTIONS
  // end of message is only ever the last char of its word
  a_eom_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> m_tlast_o)
    else $error("end of message away from end of word");
`endif

endmodule

`default_nettype wire

>>> sv/base64_stream_encoder.sv
`default_nettype none

// Base64 encoder (standard alphabet, '=' padding) for a byte stream.
// Slave channel: one message byte per word on s_axis_tdata[7:0]; s_axis_tlast
// marks the last byte of a message. Master channel: one ASCII character per
// word on m_axis_tdata[6:0]; m_axis_tlast marks the last character caused by
// an input byte, m_axis_tuser the last character of the whole message.
// Each byte gives one character (two for the third byte of a group); a final
// byte that is not the third of its group also flushes the held bits into
// one more character and pads the group with '=' to four characters, so it
// may give up to four. Throughput: one character per cycle while the
// receiver is ready, set by the single output register. A front stage
// classifies each byte and builds its characters combinationally, a short
// queue holds those words, and a back stage sends them out one character at
// a time. When the receiver stalls, the back stage holds its output and the
// queue fills; s_axis_tready drops only once it is full.
// Reset clears the group position, held bits, queue and output valid.
module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,   // final_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic            m_axis_tlast,   // end_of_run
  output logic            m_axis_tuser    // end_of_message
);
  import b64e_pkg::*;

  job_t front_job, queue_job;
  logic queue_full, queue_valid, queue_pop, take;

  // take a byte whenever the queue has room for its word
  assign s_axis_tready = !queue_full;
  assign take          = s_axis_tvalid && s_axis_tready;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .data_byte_i  (s_axis_tdata),
    .final_byte_i (s_axis_tlast),
    .job_o        (front_job)
  );

  b64e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .push_data_i (front_job),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_job)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (queue_valid),
    .job_i       (queue_job),
    .job_pop_o   (queue_pop),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire
